[sv/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the Euler to quaternion block
// Item structs, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;

   localparam int unsigned MaxStages     = 32;
   localparam int unsigned DefaultStages = 24;
   localparam int unsigned AngW          = 36;   // half angle, 2^-30 rad units
   localparam int unsigned CsW           = 34;   // CORDIC x/y, Q2.30 plus guard

   localparam logic signed [AngW-1:0] QPi     = 36'sd3373259426;
   localparam logic signed [AngW-1:0] QHalfPi = 36'sd1686629713;
   localparam logic signed [CsW-1:0]  InvGain = 34'sd652032874;
   localparam logic signed [63:0]     QHalf   = 64'sd536870912;

   typedef struct packed {
      logic signed [31:0] roll_angle;
      logic signed [31:0] pitch_angle;
      logic signed [31:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
   } rsp_type;

   // per-angle CORDIC lane state carried between cells
   typedef struct packed {
      logic signed [CsW-1:0]  x;
      logic signed [CsW-1:0]  y;
      logic signed [AngW-1:0] z;
      logic                   neg;
   } lane_type;

   function automatic logic signed [AngW-1:0] atan_entry(input int unsigned idx);
      logic [31:0] v;
      begin
         case (idx)
            0: v = 32'h3243F6A8;   1: v = 32'h1DAC6705;
            2: v = 32'h0FADBAFC;   3: v = 32'h07F56EA6;
            4: v = 32'h03FEAB76;   5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;   7: v = 32'h007FFF55;
            8: v = 32'h003FFFEA;   9: v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;  13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;  15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;  19: v = 32'h000007FF;
            20: v = 32'h000003FF;  21: v = 32'h000001FF;
            22: v = 32'h000000FF;  23: v = 32'h0000007F;
            24: v = 32'h0000003F;  25: v = 32'h0000001F;
            26: v = 32'h0000000F;  27: v = 32'h00000008;
            28: v = 32'h00000004;  29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
         endcase
         return AngW'($signed({1'b0, v}));
      end
   endfunction

endpackage

[sv/euler_to_quaternion_top.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion_top: Z-Y-X Euler angles to unit quaternion
// A new item may start every cycle (busy is always low). Its result strobes
// after one input register, one cell per CORDIC iteration, then four
// product and rounding stages. The receiver cannot stall, so results
// must be taken on their strobe cycle.
// ----------------------------------------------------------------------------
module euler_to_quaternion_top #(
   parameter int unsigned CORDIC_STAGES = e2q_pkg::DefaultStages
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  e2q_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output e2q_pkg::rsp_type  rsp_item
);

   localparam int unsigned AngW = e2q_pkg::AngW;

   logic              valid_ff;
   e2q_pkg::lane_type lane_ff [3];
   e2q_pkg::lane_type lane_in [3];
   logic signed [AngW-1:0] ang [3];

   logic              chain_valid [CORDIC_STAGES+1];
   e2q_pkg::lane_type chain_lane  [CORDIC_STAGES+1][3];

   assign busy = 1'b0;

   always_comb begin
      ang[0] = AngW'(req_item.roll_angle)  <<< 1;
      ang[1] = AngW'(req_item.pitch_angle) <<< 1;
      ang[2] = AngW'(req_item.yaw_angle)   <<< 1;
      for (int k = 0; k < 3; k++) begin
         lane_in[k].x = e2q_pkg::InvGain;
         lane_in[k].y = '0;
         if (ang[k] > e2q_pkg::QHalfPi) begin
            lane_in[k].z   = ang[k] - e2q_pkg::QPi;
            lane_in[k].neg = 1'b1;
         end else if (ang[k] < -e2q_pkg::QHalfPi) begin
            lane_in[k].z   = ang[k] + e2q_pkg::QPi;
            lane_in[k].neg = 1'b1;
         end else begin
            lane_in[k].z   = ang[k];
            lane_in[k].neg = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start;
      end
      lane_ff <= lane_in;
   end

   assign chain_valid[0] = valid_ff;
   assign chain_lane[0]  = lane_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      e2q_cell #(.STAGE(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (chain_valid[g]),
         .lane_in   (chain_lane[g]),
         .valid_out (chain_valid[g+1]),
         .lane_out  (chain_lane[g+1])
      );
   end

   e2q_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (chain_valid[CORDIC_STAGES]),
      .lane_in   (chain_lane[CORDIC_STAGES]),
      .valid_out (rsp_strobe),
      .rsp_out   (rsp_item)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(CORDIC_STAGES+5) rsp_strobe) else $error("item latency");
   a_entry: assert property (@(posedge clock) disable iff (reset)
      chain_valid[0] |-> $past(start)) else $error("entry valid");
   a_busy: assert property (@(posedge clock) !busy) else $error("busy high");

endmodule

[sv/e2q_cell.sv]
// ----------------------------------------------------------------------------
// e2q_cell: one CORDIC micro-rotation for the three angle lanes
// Registered; passes its lanes and valid to the next cell.
// ----------------------------------------------------------------------------
module e2q_cell #(
   parameter int unsigned STAGE = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_in,
   input  e2q_pkg::lane_type   lane_in  [3],
   output logic                valid_out,
   output e2q_pkg::lane_type   lane_out [3]
);

   localparam logic signed [e2q_pkg::AngW-1:0] Atan = e2q_pkg::atan_entry(STAGE);

   logic              valid_ff;
   e2q_pkg::lane_type lane_ff [3];
   e2q_pkg::lane_type lane_in_n [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lane_in_n[k].neg = lane_in[k].neg;
         if (lane_in[k].z >= 0) begin
            lane_in_n[k].x = lane_in[k].x - (lane_in[k].y >>> STAGE);
            lane_in_n[k].y = lane_in[k].y + (lane_in[k].x >>> STAGE);
            lane_in_n[k].z = lane_in[k].z - Atan;
         end else begin
            lane_in_n[k].x = lane_in[k].x + (lane_in[k].y >>> STAGE);
            lane_in_n[k].y = lane_in[k].y - (lane_in[k].x >>> STAGE);
            lane_in_n[k].z = lane_in[k].z + Atan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      lane_ff <= lane_in_n;
   end

   assign valid_out = valid_ff;
   assign lane_out  = lane_ff;

endmodule

[sv/e2q_combine.sv]
// ----------------------------------------------------------------------------
// e2q_combine: sign fix, triple products and rounding into the quaternion
// Four register stages: sign, pair products, triple products, round/saturate.
// ----------------------------------------------------------------------------
module e2q_combine (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_in,
   input  e2q_pkg::lane_type   lane_in [3],
   output logic                valid_out,
   output e2q_pkg::rsp_type    rsp_out
);

   localparam int unsigned CsW = e2q_pkg::CsW;

   logic [3:0] valid_ff;
   // sin/cos of roll, pitch, yaw: index 0 roll, 1 pitch, 2 yaw
   logic signed [CsW-1:0] s_ff [3];
   logic signed [CsW-1:0] c_ff [3];
   // rounded pair products: cc, sc, cs, ss of roll x pitch
   logic signed [CsW-1:0] pcc_ff, psc_ff, pcs_ff, pss_ff;
   logic signed [CsW-1:0] ys_ff, yc_ff;
   logic signed [63:0] sum_ff [4];
   logic signed [63:0] sum_in [4];
   e2q_pkg::rsp_type rsp_ff;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
      return (p + e2q_pkg::QHalf) >>> 30;
   endfunction

   function automatic logic signed [31:0] sat(input logic signed [63:0] s);
      logic signed [63:0] v;
      begin
         v = rnd(s);
         if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
         else if (v < -64'sd2147483648) return 32'sh80000000;
         else return v[31:0];
      end
   endfunction

   always_comb begin
      sum_in[0] = 64'(pcc_ff) * 64'(yc_ff) + 64'(pss_ff) * 64'(ys_ff);
      sum_in[1] = 64'(psc_ff) * 64'(yc_ff) - 64'(pcs_ff) * 64'(ys_ff);
      sum_in[2] = 64'(pcs_ff) * 64'(yc_ff) + 64'(psc_ff) * 64'(ys_ff);
      sum_in[3] = 64'(pcc_ff) * 64'(ys_ff) - 64'(pss_ff) * 64'(yc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], valid_in};
      end
      for (int k = 0; k < 3; k++) begin
         c_ff[k] <= lane_in[k].neg ? -lane_in[k].x : lane_in[k].x;
         s_ff[k] <= lane_in[k].neg ? -lane_in[k].y : lane_in[k].y;
      end
      pcc_ff <= CsW'(rnd(64'(c_ff[0]) * 64'(c_ff[1])));
      psc_ff <= CsW'(rnd(64'(s_ff[0]) * 64'(c_ff[1])));
      pcs_ff <= CsW'(rnd(64'(c_ff[0]) * 64'(s_ff[1])));
      pss_ff <= CsW'(rnd(64'(s_ff[0]) * 64'(s_ff[1])));
      yc_ff  <= c_ff[2];
      ys_ff  <= s_ff[2];
      sum_ff <= sum_in;
      rsp_ff.quat_w <= sat(sum_ff[0]);
      rsp_ff.quat_x <= sat(sum_ff[1]);
      rsp_ff.quat_y <= sat(sum_ff[2]);
      rsp_ff.quat_z <= sat(sum_ff[3]);
   end

   assign valid_out = valid_ff[3];
   assign rsp_out   = rsp_ff;

   a_valid_delay: assert property (@(posedge clock) disable iff (reset)
      valid_in |-> ##4 valid_out) else $error("combine latency");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      valid_out |-> $past(valid_ff[2])) else $error("combine valid");
   a_chain: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff[1]) |-> $past(valid_ff[0])) else $error("combine chain");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for euler_to_quaternion_top
// Drives angle triples through the command port, predicts each quaternion
// with an independent CORDIC and product model, and checks every strobed
// result in order against the queue of predicted quaternions.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned Stages      = e2q_pkg::DefaultStages;
   localparam int unsigned Latency     = Stages + 5;
   localparam int unsigned RandomItems = 830;
   localparam int unsigned WatchLimit  = 4000;
   localparam int unsigned TableRows   = 17;
   localparam longint      PiQ30       = 64'sd3373259426;
   localparam longint      HalfPiQ30   = 64'sd1686629713;
   localparam longint      StartX      = 64'sd652032874;

   typedef struct {
      logic [31:0]      roll;
      logic [31:0]      pitch;
      logic [31:0]      yaw;
      bit               known;
      e2q_pkg::rsp_type quat;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   e2q_pkg::req_type req_item = '0;
   logic             rsp_strobe;
   e2q_pkg::rsp_type rsp_item;

   e2q_pkg::rsp_type quat_queue[$];
   int unsigned error_count  = 0;
   int unsigned item_count   = 0;
   int unsigned result_count = 0;
   int unsigned reduced_count = 0;
   int unsigned idle_cycles  = 0;
   int unsigned send_idle    = 0;
   stim_row_type stim_table [TableRows];

   longint arctan_tab[32] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
      64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008,
      64'h00000004, 64'h00000002, 64'h00000001, 64'h00000000};

   euler_to_quaternion_top #(.CORDIC_STAGES(Stages)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always #2 clock = ~clock;

   function automatic void half_angle_sincos(input logic [31:0] raw,
                                             output longint s, output longint c);
      longint ang;
      longint x;
      longint y;
      longint dx;
      longint dy;
      bit     flip;
      ang  = longint'($signed(raw)) * 2;
      x    = StartX;
      y    = 0;
      flip = 1'b0;
      if (ang > HalfPiQ30) begin
         ang  = ang - PiQ30;
         flip = 1'b1;
      end else if (ang < -HalfPiQ30) begin
         ang  = ang + PiQ30;
         flip = 1'b1;
      end
      for (int i = 0; i < Stages; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (ang >= 0) begin
            x   = x - dx;
            y   = y + dy;
            ang = ang - arctan_tab[i];
         end else begin
            x   = x + dx;
            y   = y - dy;
            ang = ang + arctan_tab[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint round_q30(input longint p);
      return (p + 64'sd536870912) >>> 30;
   endfunction

   function automatic longint triple_product(input longint a, input longint b,
                                             input longint c);
      return round_q30(a * b) * c;
   endfunction

   function automatic logic [31:0] clamp_q30(input longint sum);
      longint v;
      v = round_q30(sum);
      if (v > 64'sd2147483647)
         v = 64'sd2147483647;
      if (v < -64'sd2147483648)
         v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic e2q_pkg::rsp_type predict_quaternion(input e2q_pkg::req_type a);
      longint sr, cr, sp, cp, sy, cy;
      e2q_pkg::rsp_type q;
      half_angle_sincos(a.roll_angle, sr, cr);
      half_angle_sincos(a.pitch_angle, sp, cp);
      half_angle_sincos(a.yaw_angle, sy, cy);
      q.quat_w = clamp_q30(triple_product(cr, cp, cy) + triple_product(sr, sp, sy));
      q.quat_x = clamp_q30(triple_product(sr, cp, cy) - triple_product(cr, sp, sy));
      q.quat_y = clamp_q30(triple_product(cr, sp, cy) + triple_product(sr, cp, sy));
      q.quat_z = clamp_q30(triple_product(cr, cp, sy) - triple_product(sr, sp, cy));
      return q;
   endfunction

   function automatic bit needs_reduction(input logic [31:0] raw);
      longint ang;
      ang = longint'($signed(raw)) * 2;
      return (ang > HalfPiQ30) || (ang < -HalfPiQ30);
   endfunction

   function automatic logic [31:0] random_angle();
      case ($urandom_range(9))
         0: return $urandom_range(32'd843314857, 32'd843314855);
         1: return -$urandom_range(32'd843314857, 32'd843314855);
         2: return $urandom_range(255) - 128;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_angles(input logic [31:0] roll, input logic [31:0] pitch,
                              input logic [31:0] yaw, input bit known,
                              input e2q_pkg::rsp_type quat);
      e2q_pkg::req_type a;
      e2q_pkg::rsp_type q;
      while ($urandom_range(99) < send_idle) begin
         start <= 1'b0;
         @(posedge clock);
      end
      a.roll_angle  = roll;
      a.pitch_angle = pitch;
      a.yaw_angle   = yaw;
      start    <= 1'b1;
      req_item <= a;
      do
         @(posedge clock);
      while (busy);
      q = predict_quaternion(a);
      if (known && q !== quat) begin
         $error("table row mismatch: typed %h predicted %h", quat, q);
         error_count++;
      end
      quat_queue = {quat_queue, q};
      item_count++;
      if (needs_reduction(roll) || needs_reduction(pitch) || needs_reduction(yaw))
         reduced_count++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (quat_queue.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] expv,
                              input logic [31:0] actv);
      if (expv !== actv) begin
         $error("%s mismatch: expected %h actual %h", name, expv, actv);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      e2q_pkg::rsp_type q;
      if (!reset && rsp_strobe) begin
         result_count++;
         if (quat_queue.size() == 0) begin
            $error("unexpected result %h", rsp_item);
            error_count++;
         end else begin
            q = quat_queue.pop_front();
            check_field("quat_w", q.quat_w, rsp_item.quat_w);
            check_field("quat_x", q.quat_x, rsp_item.quat_x);
            check_field("quat_y", q.quat_y, rsp_item.quat_y);
            check_field("quat_z", q.quat_z, rsp_item.quat_z);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("watchdog expired");
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      stim_row_type r;
      stim_table = '{
         '{32'h0, 32'h0, 32'h0, 1'b0, '0},
         '{32'h7FFFFFFF, 32'h0, 32'h0, 1'b0, '0},
         '{32'h80000000, 32'h0, 32'h0, 1'b0, '0},
         '{32'h0, 32'h7FFFFFFF, 32'h0, 1'b0, '0},
         '{32'h0, 32'h80000000, 32'h0, 1'b0, '0},
         '{32'h0, 32'h0, 32'h7FFFFFFF, 1'b0, '0},
         '{32'h0, 32'h0, 32'h80000000, 1'b0, '0},
         '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, '0},
         '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0, '0},
         '{32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 1'b0, '0},
         '{32'd843314856, 32'd843314856, 32'd843314856, 1'b0, '0},
         '{32'd843314857, 32'd843314857, 32'd843314857, 1'b0, '0},
         '{-32'd843314856, -32'd843314856, -32'd843314856, 1'b0, '0},
         '{-32'd843314857, -32'd843314857, -32'd843314857, 1'b0, '0},
         '{32'd1686629713, -32'd1686629713, 32'd421657428, 1'b0, '0},
         '{32'h55555555, 32'hAAAAAAAA, 32'h33333333, 1'b0, '0},
         '{32'hAAAAAAAA, 32'h55555555, 32'hCCCCCCCC, 1'b0, '0}};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (stim_table[k]) begin
         r = stim_table[k];
         send_angles(r.roll, r.pitch, r.yaw, r.known, r.quat);
      end
      drain_results();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 11 : (phase == 1) ? 60 : 0;
         for (int n = 0; n < RandomItems / 3; n++)
            send_angles(random_angle(), random_angle(), random_angle(), 1'b0, '0);
         drain_results();
      end
      repeat (Latency + 4) @(posedge clock);
      $display("covered %0d angle items (%0d with half-angle reduction), %0d results",
               item_count, reduced_count, result_count);
      $display("sender idle phases 11%%, 60%% and none; drained between phases");
      if (error_count == 0 && quat_queue.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
